// ===== rtl/lbb_pkg.sv =====
// Shared types, constants and microcode for the LSB-first bit buffer.
// Used by lbb_store and lsb_first_bit_buffer; no dependencies.
package lbb_pkg;

  localparam int StoreDepth = 4096;
  localparam int StoreAddrW = $clog2(StoreDepth);
  localparam int CapW       = 13;
  localparam int PosW       = CapW + 3;
  localparam int UpcW       = 4;
  localparam int CntW       = 4;

  localparam logic [1:0] RegCapacity = 2'd0;

  // microprogram entry points
  localparam logic [UpcW-1:0] UpcEntry   = 4'd0;
  localparam logic [UpcW-1:0] UpcWrBytes = 4'd1;
  localparam logic [UpcW-1:0] UpcRdBytes = 4'd2;
  localparam logic [UpcW-1:0] UpcDrain   = 4'd3;
  localparam logic [UpcW-1:0] UpcBitRd0  = 4'd4;
  localparam logic [UpcW-1:0] UpcBitRd1  = 4'd5;
  localparam logic [UpcW-1:0] UpcBitWait = 4'd6;
  localparam logic [UpcW-1:0] UpcFin     = 4'd7;
  localparam logic [UpcW-1:0] UpcBitLo   = 4'd8;
  localparam logic [UpcW-1:0] UpcBitHi   = 4'd9;

  typedef enum logic [3:0] {
    OP_RESET_POS = 4'd0,
    OP_WR_BITS   = 4'd1,
    OP_WR_BYTE   = 4'd2,
    OP_WR_W32    = 4'd3,
    OP_WR_W64    = 4'd4,
    OP_RD_BITS   = 4'd5,
    OP_RD_BYTE   = 4'd6,
    OP_RD_W32    = 4'd7,
    OP_RD_W64    = 4'd8,
    OP_POP_TAIL  = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_CAP = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_CHECK   = 3'd1,
    ACT_WRITE   = 3'd2,
    ACT_READ    = 3'd3,
    ACT_WBIT_LO = 3'd4,
    ACT_WBIT_HI = 3'd5,
    ACT_FINISH  = 3'd6
  } act_e;

  typedef enum logic [2:0] {
    JMP_NEXT  = 3'd0,
    JMP_GOTO  = 3'd1,
    JMP_LOOP  = 3'd2,
    JMP_DISP  = 3'd3,
    JMP_IFWR  = 3'd4,
    JMP_IFSTR = 3'd5,
    JMP_END   = 3'd6
  } jmp_e;

  typedef struct packed {
    act_e            act;
    jmp_e            jmp;
    logic [UpcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic                  en;
    logic                  we;
    logic [StoreAddrW-1:0] addr;
    logic [7:0]            wdata;
  } store_req_t;

  // control store: one word per step
  function automatic ucode_t lbb_ucode(input logic [UpcW-1:0] upc);
    ucode_t w;
    w = '{act: ACT_NONE, jmp: JMP_END, target: UpcFin};
    case (upc)
      UpcEntry:   w = '{act: ACT_CHECK,   jmp: JMP_DISP,  target: UpcFin};
      UpcWrBytes: w = '{act: ACT_WRITE,   jmp: JMP_LOOP,  target: UpcFin};
      UpcRdBytes: w = '{act: ACT_READ,    jmp: JMP_LOOP,  target: UpcDrain};
      UpcDrain:   w = '{act: ACT_NONE,    jmp: JMP_GOTO,  target: UpcFin};
      UpcBitRd0:  w = '{act: ACT_READ,    jmp: JMP_NEXT,  target: UpcFin};
      UpcBitRd1:  w = '{act: ACT_READ,    jmp: JMP_NEXT,  target: UpcFin};
      UpcBitWait: w = '{act: ACT_NONE,    jmp: JMP_IFWR,  target: UpcBitLo};
      UpcFin:     w = '{act: ACT_FINISH,  jmp: JMP_END,   target: UpcFin};
      UpcBitLo:   w = '{act: ACT_WBIT_LO, jmp: JMP_IFSTR, target: UpcFin};
      UpcBitHi:   w = '{act: ACT_WBIT_HI, jmp: JMP_GOTO,  target: UpcFin};
      default:    w = '{act: ACT_NONE,    jmp: JMP_END,   target: UpcFin};
    endcase
    return w;
  endfunction

  // low n bits set, n up to 8
  function automatic logic [7:0] lbb_mask8(input logic [3:0] n);
    logic [8:0] m;
    m = (9'd1 << n) - 9'd1;
    return m[7:0];
  endfunction

endpackage

// ===== rtl/lbb_store.sv =====
// Byte store of the bit buffer: one shared port, registered read data.
// Depends on lbb_pkg for the depth and the request struct.
module lbb_store
  import lbb_pkg::*;
(
  input  logic       clk_i,
  input  store_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [StoreDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lsb_first_bit_buffer.sv =====
// LSB-first bit packer/unpacker over a 4096-byte store, microcoded control.
// A new operation is accepted only while busy is low, so each runs to its result strobe
// before the next is taken; all store accesses go through the byte store's single port.
// Busy drops in the strobe cycle, so the next operation can be accepted while the strobe shows.
// Reset clears position, capacity (to 4096) and control; store contents stay undefined.
// Results are strobed for one cycle; the receiver cannot stall. Depends on lbb_pkg.
module lsb_first_bit_buffer
  import lbb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        operation_i,
  input  logic [63:0]       write_value_i,
  input  logic [3:0]        bit_count_i,
  output logic              result_valid_o,
  output logic [63:0]       read_data_o,
  output logic [1:0]        status_o,
  output logic [CapW-1:0]   byte_position_o,
  output logic [2:0]        bit_position_o,
  output logic [15:0]       bits_remaining_o,
  output logic              has_more_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // sequencer
  logic            run_q;
  logic [UpcW-1:0] upc_q, upc_d;
  ucode_t          uc;

  // transaction registers
  op_e             op_q;
  logic [63:0]     wv_q;
  logic [3:0]      len_q;

  // position and configuration
  logic [CapW-1:0] bi_q;
  logic [2:0]      bo_q;
  logic [CapW-1:0] cap_q;
  logic [CapW-1:0] cap_eff;

  // datapath
  status_e         status_q, status_d;
  logic            commit_q, commit_d;
  logic [PosW-1:0] npos_q, npos_d;
  logic [StoreAddrW-1:0] addr_q, addr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [63:0]     sh_q;
  logic [63:0]     sh_load;
  logic            load_sh;
  logic            rd_pend_q;
  logic [UpcW-1:0] entry_tgt;

  // position arithmetic
  logic [PosW-1:0] pos_cur;
  logic [PosW-1:0] cap_bits;
  logic [PosW:0]   end_bits;
  logic [CapW:0]   astart;
  logic [CapW:0]   aend;
  logic [CntW-1:0] nbytes;

  // bit path and finish
  logic            straddle;
  logic [7:0]      vbits;
  logic [15:0]     new16;
  logic [15:0]     bits_win;
  logic [63:0]     fin_data;
  logic [PosW-1:0] fpos;
  logic [CapW:0]   fbytepos;

  store_req_t      req;
  logic [7:0]      rdata;

  logic            accept;
  logic            cfg_wr;

  lbb_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign accept = start & ~run_q;
  assign busy   = run_q;
  assign uc     = lbb_ucode(upc_q);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & ((paddr >> 2) == RegCapacity);
  assign prdata = {{(32 - CapW){1'b0}}, cap_q};
  assign cap_eff = (cap_q > CapW'(StoreDepth)) ? CapW'(StoreDepth) : cap_q;

  assign pos_cur  = {bi_q, bo_q};
  assign cap_bits = {cap_eff, 3'b000};
  assign end_bits = {1'b0, pos_cur} + (PosW + 1)'(len_q);
  assign astart   = {1'b0, bi_q} + (CapW + 1)'(bo_q != 3'd0);
  assign aend     = astart + (CapW + 1)'(nbytes);

  always_comb begin
    unique case (op_q)
      OP_WR_BYTE, OP_RD_BYTE: nbytes = 4'd1;
      OP_WR_W32, OP_RD_W32:   nbytes = 4'd4;
      default:                nbytes = 4'd8;
    endcase
  end

  // check the transaction and pick the microprogram entry
  always_comb begin
    status_d  = ST_OK;
    commit_d  = 1'b0;
    npos_d    = pos_cur;
    entry_tgt = UpcFin;
    addr_d    = bi_q[StoreAddrW-1:0];
    count_d   = nbytes;
    load_sh   = 1'b0;
    sh_load   = wv_q;
    unique case (op_q)
      OP_RESET_POS: begin
        commit_d = 1'b1;
        npos_d   = '0;
      end
      OP_WR_BITS, OP_RD_BITS: begin
        if (len_q > 4'd8) begin
          status_d = ST_LEN;
        end else if (len_q != 4'd0) begin
          if (end_bits > {1'b0, cap_bits}) begin
            status_d = ST_CAP;
          end else begin
            commit_d  = 1'b1;
            npos_d    = end_bits[PosW-1:0];
            entry_tgt = UpcBitRd0;
          end
        end
      end
      OP_WR_BYTE, OP_WR_W32, OP_WR_W64, OP_RD_BYTE, OP_RD_W32, OP_RD_W64: begin
        addr_d = astart[StoreAddrW-1:0];
        if (aend > {1'b0, cap_eff}) begin
          status_d = ST_CAP;
        end else begin
          commit_d = 1'b1;
          npos_d   = {aend[CapW-1:0], 3'b000};
          if (op_q == OP_WR_BYTE || op_q == OP_WR_W32 || op_q == OP_WR_W64) begin
            entry_tgt = UpcWrBytes;
            load_sh   = 1'b1;
            // high word goes out first for the 64-bit write
            if (op_q == OP_WR_W64) begin
              sh_load = {wv_q[31:0], wv_q[63:32]};
            end
          end else begin
            entry_tgt = UpcRdBytes;
          end
        end
      end
      OP_POP_TAIL: begin
        if (bo_q != 3'd0) begin
          if (bi_q >= cap_eff) begin
            status_d = ST_CAP;
          end else begin
            commit_d  = 1'b1;
            npos_d    = {bi_q, 3'b000};
            entry_tgt = UpcBitRd0;
          end
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // bit write: keep the bits below the offset, fresh zeros above
  assign straddle = ({1'b0, bo_q} + len_q) > 4'd8;
  assign vbits    = wv_q[7:0] & lbb_mask8(len_q);
  assign new16    = {8'b0, sh_q[55:48] & lbb_mask8({1'b0, bo_q})} | ({8'b0, vbits} << bo_q);
  assign bits_win = sh_q[63:48] >> bo_q;

  // next microprogram address
  always_comb begin
    upc_d = upc_q + 1'b1;
    unique case (uc.jmp)
      JMP_NEXT:  upc_d = upc_q + 1'b1;
      JMP_GOTO:  upc_d = uc.target;
      JMP_LOOP:  upc_d = (count_q != CntW'(1)) ? upc_q : uc.target;
      JMP_DISP:  upc_d = entry_tgt;
      JMP_IFWR:  upc_d = (op_q == OP_WR_BITS) ? uc.target : UpcFin;
      JMP_IFSTR: upc_d = straddle ? upc_q + 1'b1 : uc.target;
      JMP_END:   upc_d = UpcEntry;
      default:   upc_d = UpcEntry;
    endcase
  end

  // store port
  always_comb begin
    req = '0;
    if (run_q) begin
      unique case (uc.act)
        ACT_WRITE: begin
          req.en    = 1'b1;
          req.we    = 1'b1;
          req.addr  = addr_q;
          req.wdata = sh_q[7:0];
        end
        ACT_READ: begin
          req.en   = 1'b1;
          req.addr = addr_q;
        end
        ACT_WBIT_LO: begin
          req.en    = 1'b1;
          req.we    = 1'b1;
          req.addr  = bi_q[StoreAddrW-1:0];
          req.wdata = new16[7:0];
        end
        ACT_WBIT_HI: begin
          req.en    = 1'b1;
          req.we    = 1'b1;
          req.addr  = bi_q[StoreAddrW-1:0] + 1'b1;
          req.wdata = new16[15:8];
        end
        default: begin
          req = '0;
        end
      endcase
    end
  end

  // result data; the gather register holds bytes in arrival order at its top
  always_comb begin
    fin_data = '0;
    if (commit_q) begin
      unique case (op_q)
        OP_RD_BITS:  fin_data = {56'b0, bits_win[7:0] & lbb_mask8(len_q)};
        OP_RD_BYTE:  fin_data = {56'b0, sh_q[63:56]};
        OP_RD_W32:   fin_data = {32'b0, sh_q[63:32]};
        OP_RD_W64:   fin_data = {sh_q[31:0], sh_q[63:32]};
        OP_POP_TAIL: fin_data = {56'b0, sh_q[55:48] & lbb_mask8({1'b0, bo_q})};
        default:     fin_data = '0;
      endcase
    end
  end

  assign fpos     = commit_q ? npos_q : pos_cur;
  assign fbytepos = {1'b0, fpos[PosW-1:3]} + (CapW + 1)'(fpos[2:0] != 3'd0);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q          <= 1'b0;
      upc_q          <= UpcEntry;
      rd_pend_q      <= 1'b0;
      result_valid_o <= 1'b0;
      bi_q           <= '0;
      bo_q           <= '0;
      cap_q          <= CapW'(StoreDepth);
    end else begin
      rd_pend_q      <= run_q && (uc.act == ACT_READ);
      result_valid_o <= run_q && (uc.act == ACT_FINISH);
      if (cfg_wr) begin
        cap_q <= pwdata[CapW-1:0];
      end
      if (accept) begin
        run_q <= 1'b1;
        upc_q <= UpcEntry;
      end else if (run_q) begin
        upc_q <= upc_d;
        if (uc.jmp == JMP_END) begin
          run_q <= 1'b0;
        end
        if (uc.act == ACT_FINISH) begin
          bi_q <= fpos[PosW-1:3];
          bo_q <= fpos[2:0];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      wv_q  <= write_value_i;
      len_q <= bit_count_i;
    end
    if (run_q && uc.act == ACT_CHECK) begin
      status_q <= status_d;
      commit_q <= commit_d;
      npos_q   <= npos_d;
      addr_q   <= addr_d;
      count_q  <= count_d;
    end else if (run_q && (uc.act == ACT_READ || uc.act == ACT_WRITE)) begin
      addr_q  <= addr_q + 1'b1;
      count_q <= count_q - 1'b1;
    end
    // shift out write bytes; shift in each read byte in the cycle after its read
    if (run_q && uc.act == ACT_CHECK && load_sh) begin
      sh_q <= sh_load;
    end else if (run_q && uc.act == ACT_WRITE) begin
      sh_q <= {8'b0, sh_q[63:8]};
    end else if (rd_pend_q) begin
      sh_q <= {rdata, sh_q[63:8]};
    end
    if (run_q && uc.act == ACT_FINISH) begin
      read_data_o      <= fin_data;
      status_o         <= status_q;
      byte_position_o  <= fbytepos[CapW-1:0];
      bit_position_o   <= fpos[2:0];
      bits_remaining_o <= (cap_bits > fpos) ? (cap_bits - fpos) : '0;
      has_more_o       <= fbytepos < {1'b0, cap_eff};
    end
  end

endmodule

// ===== test/lsb_first_bit_buffer_test.sv =====
// Self-checking testbench for lsb_first_bit_buffer: a directed opening, a fill of the whole
// store, mostly with 64-bit words, then random streams under several capacity settings.
// Depends on lbb_pkg and lsb_first_bit_buffer only.
module lsb_first_bit_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lbb_pkg::*;

  localparam logic [1:0]      CapacityAddr = 2'(4 * RegCapacity);
  localparam logic [CapW-1:0] CapReset     = 13'd4096;
  localparam logic [3:0]      OP_UNUSED_TOP = 4'd15;

  typedef struct packed {
    logic [63:0]     data;
    status_e         status;
    logic [CapW-1:0] bytepos;
    logic [2:0]      bitpos;
    logic [15:0]     remain;
    logic            more;
  } report_t;

  typedef struct {
    bit              cfg;
    logic [3:0]      op;
    logic [63:0]     value;
    logic [3:0]      count;
    logic [CapW-1:0] cap;
    int unsigned     gap;
  } job_t;

  typedef enum logic [6:0] {
    DRV_NEXT   = 7'b0000001,
    DRV_GAP    = 7'b0000010,
    DRV_ITEM   = 7'b0000100,
    DRV_DRAIN  = 7'b0001000,
    DRV_SETUP  = 7'b0010000,
    DRV_ACCESS = 7'b0100000,
    DRV_DONE   = 7'b1000000
  } drv_state_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic [3:0]  operation_i   = '0;
  logic [63:0] write_value_i = '0;
  logic [3:0]  bit_count_i   = '0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [1:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;

  logic            busy;
  logic            result_valid_o;
  logic [63:0]     read_data_o;
  logic [1:0]      status_o;
  logic [CapW-1:0] byte_position_o;
  logic [2:0]      bit_position_o;
  logic [15:0]     bits_remaining_o;
  logic            has_more_o;
  logic [31:0]     prdata;
  logic            pready;

  lsb_first_bit_buffer uut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .write_value_i, .bit_count_i,
    .result_valid_o, .read_data_o, .status_o, .byte_position_o, .bit_position_o,
    .bits_remaining_o, .has_more_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // Two copies of the buffer state: copy 0 shadows the stimulus as it is planned,
  // copy 1 follows the transactions the block actually accepts.
  logic [7:0]  store_img [2][StoreDepth];
  bit          seen [StoreDepth];
  int unsigned cur_idx [2];
  int unsigned cur_off [2];
  int unsigned cap_reg [2];

  job_t        op_backlog [$];
  report_t     due_reports [$];
  job_t        cur_job;
  drv_state_e  drv_state = DRV_NEXT;
  int unsigned gap_left = 0;
  int unsigned ops_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned cap_writes = 0;
  int unsigned fail_n = 0;
  int unsigned status_hits [4];
  bit          stim_done = 1'b0;
  bit          no_gaps = 1'b0;

  function automatic int unsigned eff_cap(input int c);
    return cap_reg[c] > StoreDepth ? StoreDepth : cap_reg[c];
  endfunction

  function automatic int unsigned span_of(input logic [3:0] op);
    case (op)
      OP_WR_BYTE, OP_RD_BYTE: return 1;
      OP_WR_W32, OP_RD_W32:   return 4;
      default:                return 8;
    endcase
  endfunction

  // Apply one operation to state copy c and return the report it produces.
  function automatic report_t run_buffer_op(input int c, input logic [3:0] op,
                                            input logic [63:0] wv, input logic [3:0] count);
    int unsigned cap, idx, off, len, m, v, keep, p, n, s, sh, pos, capb, bpos;
    logic [63:0] data;
    status_e     st;
    report_t     r;
    bit          wr;
    cap  = eff_cap(c);
    idx  = cur_idx[c];
    off  = cur_off[c];
    len  = count;
    data = '0;
    st   = ST_OK;
    case (op)
      OP_RESET_POS: begin
        idx = 0;
        off = 0;
      end
      OP_WR_BITS, OP_RD_BITS: begin
        p = idx * 8 + off;
        if (len > 8) begin
          st = ST_LEN;
        end else if (len != 0) begin
          if (p + len > cap * 8) begin
            st = ST_CAP;
          end else begin
            m = (1 << len) - 1;
            if (op == OP_WR_BITS) begin
              // bits above the write offset start fresh
              v    = wv[31:0] & m;
              keep = 32'(store_img[c][idx]) & ((1 << off) - 1);
              store_img[c][idx] = 8'(keep | (v << off));
              if (c == 0) seen[idx] = 1'b1;
              if (off + len > 8) begin
                store_img[c][idx + 1] = 8'(v >> (8 - off));
                if (c == 0) seen[idx + 1] = 1'b1;
              end
            end else begin
              v = 32'(store_img[c][idx]) >> off;
              if (off + len > 8) v = v | (32'(store_img[c][idx + 1]) << (8 - off));
              data = 64'(v & m);
            end
            p   = p + len;
            idx = p >> 3;
            off = p & 7;
          end
        end
      end
      OP_WR_BYTE, OP_WR_W32, OP_WR_W64, OP_RD_BYTE, OP_RD_W32, OP_RD_W64: begin
        n  = span_of(op);
        s  = idx + (off != 0 ? 1 : 0);
        wr = (op == OP_WR_BYTE || op == OP_WR_W32 || op == OP_WR_W64);
        if (s + n > cap) begin
          st = ST_CAP;
        end else begin
          // 64-bit numbers go high word first, each word low byte first
          for (int i = 0; i < n; i++) begin
            sh = (n == 8) ? ((i < 4) ? 32 + 8 * i : 8 * (i - 4)) : 8 * i;
            if (wr) begin
              store_img[c][s + i] = wv[sh +: 8];
              if (c == 0) seen[s + i] = 1'b1;
            end else begin
              data[sh +: 8] = store_img[c][s + i];
            end
          end
          idx = s + n;
          off = 0;
        end
      end
      OP_POP_TAIL: begin
        if (off != 0) begin
          if (idx >= cap) begin
            st = ST_CAP;
          end else begin
            data = 64'(32'(store_img[c][idx]) & ((1 << off) - 1));
            off  = 0;
          end
        end
      end
      default: ;
    endcase
    cur_idx[c] = idx;
    cur_off[c] = off;
    pos  = idx * 8 + off;
    capb = cap * 8;
    bpos = idx + (off != 0 ? 1 : 0);
    r.data    = data;
    r.status  = st;
    r.bytepos = CapW'(bpos);
    r.bitpos  = 3'(off);
    r.remain  = 16'(capb > pos ? capb - pos : 0);
    r.more    = bpos < cap;
    return r;
  endfunction

  // True unless the operation would read a store byte never written.
  function automatic bit safe_read(input logic [3:0] op, input logic [3:0] count);
    int unsigned cap, first, n, p;
    cap   = eff_cap(0);
    first = cur_idx[0] + (cur_off[0] != 0 ? 1 : 0);
    n     = 0;
    case (op)
      OP_RD_BITS: begin
        p = cur_idx[0] * 8 + cur_off[0];
        if (count != 0 && count <= 8 && p + count <= cap * 8) begin
          first = cur_idx[0];
          n     = (cur_off[0] + count > 8) ? 2 : 1;
        end
      end
      OP_RD_BYTE, OP_RD_W32, OP_RD_W64: begin
        n = span_of(op);
        if (first + n > cap) n = 0;
      end
      OP_POP_TAIL: begin
        if (cur_off[0] != 0 && cur_idx[0] < cap) begin
          first = cur_idx[0];
          n     = 1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) if (!seen[first + i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic add_op(input logic [3:0] op, input logic [63:0] value,
                        input logic [3:0] count);
    job_t j;
    if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
    j.cfg   = 1'b0;
    j.op    = op;
    j.value = value;
    j.count = count;
    j.cap   = '0;
    j.gap   = no_gaps ? 0 : $urandom_range(0, 17);
    op_backlog.insert(op_backlog.size(), j);
    void'(run_buffer_op(0, op, value, count));
  endtask

  task automatic add_capacity(input logic [CapW-1:0] value);
    job_t j;
    j.cfg   = 1'b1;
    j.op    = OP_RESET_POS;
    j.value = '0;
    j.count = '0;
    j.cap   = value;
    j.gap   = 0;
    op_backlog.insert(op_backlog.size(), j);
    cap_reg[0] = value;
  endtask

  // In a sweep, mostly 64-bit words and no position resets, so the store fills up.
  task automatic add_random(input bit sweep);
    int unsigned roll;
    logic [3:0]  op;
    logic [3:0]  count;
    roll = $urandom_range(0, 99);
    if (roll < 6)       op = sweep ? OP_RD_BITS : OP_RESET_POS;
    else if (roll < 26) op = OP_WR_BITS;
    else if (roll < 34) op = OP_WR_BYTE;
    else if (roll < 42) op = OP_WR_W32;
    else if (roll < 50) op = OP_WR_W64;
    else if (roll < 70) op = OP_RD_BITS;
    else if (roll < 78) op = OP_RD_BYTE;
    else if (roll < 85) op = OP_RD_W32;
    else if (roll < 92) op = OP_RD_W64;
    else if (roll < 98) op = OP_POP_TAIL;
    else                op = 4'(OP_POP_TAIL + $urandom_range(1, 6));
    if (sweep && $urandom_range(0, 9) < 7) op = OP_WR_W64;
    count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    // turn a read of fresh bytes into the matching write
    if (!safe_read(op, count)) begin
      case (op)
        OP_RD_BITS: op = OP_WR_BITS;
        OP_RD_BYTE: op = OP_WR_BYTE;
        OP_RD_W32:  op = OP_WR_W32;
        OP_RD_W64:  op = OP_WR_W64;
        default: ;
      endcase
    end
    add_op(op, {$urandom, $urandom}, count);
  endtask

  task automatic present();
    start         <= 1'b1;
    operation_i   <= cur_job.op;
    write_value_i <= cur_job.value;
    bit_count_i   <= cur_job.count;
    drv_state     <= DRV_ITEM;
  endtask

  task automatic load_next();
    if (op_backlog.size() == 0) begin
      start     <= 1'b0;
      stim_done <= 1'b1;
      drv_state <= DRV_DONE;
    end else begin
      cur_job = op_backlog.pop_front();
      if (cur_job.cfg) begin
        start     <= 1'b0;
        drv_state <= DRV_DRAIN;
      end else if (cur_job.gap == 0) begin
        present();
      end else begin
        start     <= 1'b0;
        gap_left  <= cur_job.gap;
        drv_state <= DRV_GAP;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      case (drv_state)
        DRV_NEXT: load_next();
        DRV_GAP: begin
          if (gap_left <= 1) present();
          else gap_left <= gap_left - 1;
        end
        DRV_ITEM: begin
          if (!busy) begin
            due_reports.insert(due_reports.size(),
                               run_buffer_op(1, operation_i, write_value_i, bit_count_i));
            ops_sent <= ops_sent + 1;
            load_next();
          end
        end
        DRV_DRAIN: begin
          // hold the register write until the block is idle
          if (ops_sent == reports_seen && !busy && !result_valid_o) begin
            psel      <= 1'b1;
            penable   <= 1'b0;
            pwrite    <= 1'b1;
            paddr     <= CapacityAddr;
            pwdata    <= 32'(cur_job.cap);
            drv_state <= DRV_SETUP;
          end
        end
        DRV_SETUP: begin
          penable   <= 1'b1;
          drv_state <= DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (pready) begin
            cap_reg[1] = cur_job.cap;
            psel       <= 1'b0;
            penable    <= 1'b0;
            pwrite     <= 1'b0;
            cap_writes <= cap_writes + 1;
            load_next();
          end
        end
        default: ;
      endcase
    end
  end

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    report_t want;
    int      bad;
    if (rst_ni && result_valid_o) begin
      bad = 0;
      // only expectations queued before this edge count
      if (ops_sent == reports_seen) begin
        $error("result strobe with no transaction outstanding");
        bad = 1;
      end else begin
        want = due_reports.pop_front();
        bad += field_differs("read_data", want.data, read_data_o);
        bad += field_differs("status", want.status, status_o);
        bad += field_differs("byte_position", want.bytepos, byte_position_o);
        bad += field_differs("bit_position", want.bitpos, bit_position_o);
        bad += field_differs("bits_remaining", want.remain, bits_remaining_o);
        bad += field_differs("has_more", want.more, has_more_o);
        status_hits[want.status] = status_hits[want.status] + 1;
        reports_seen <= reports_seen + 1;
      end
      fail_n = fail_n + bad;
    end
  end

  initial begin
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < StoreDepth; i++) store_img[c][i] = '0;
      cur_idx[c] = 0;
      cur_off[c] = 0;
      cap_reg[c] = CapReset;
    end
    for (int i = 0; i < StoreDepth; i++) seen[i] = 1'b0;
    for (int i = 0; i < 4; i++) status_hits[i] = 0;

    // directed: length errors, straddles, tail pops, every width, then read back
    add_op(OP_WR_BITS, '1, 4'd0);
    add_op(OP_WR_BITS, {$urandom, $urandom}, 4'd9);
    add_op(OP_RD_BITS, {$urandom, $urandom}, 4'd15);
    add_op(OP_WR_BITS, '1, 4'd5);
    add_op(OP_WR_BITS, 64'hFFFF_FFFF_FFFF_FF5A, 4'd8);
    add_op(OP_POP_TAIL, '0, 4'd0);
    add_op(OP_WR_BITS, 64'h0000_0000_0000_0005, 4'd3);
    add_op(OP_WR_BYTE, 64'h0123_4567_89AB_CDA5, 4'd0);
    add_op(OP_WR_W32, '0, 4'd0);
    add_op(OP_WR_W64, '1, 4'd0);
    add_op(OP_UNUSED_TOP, '1, 4'd15);
    add_op(OP_RESET_POS, '0, 4'd0);
    add_op(OP_RD_BITS, '0, 4'd5);
    add_op(OP_RD_BITS, '0, 4'd8);
    add_op(OP_RD_BITS, '1, 4'd0);
    add_op(OP_RD_BYTE, '0, 4'd0);
    add_op(OP_RD_W32, '0, 4'd0);
    add_op(OP_RD_W64, '0, 4'd0);
    add_op(OP_POP_TAIL, '0, 4'd0);
    add_op(OP_WR_BITS, 64'h0000_0000_0000_0055, 4'd7);
    // shrink capacity below the current byte: tail pop and writes must refuse
    add_capacity(13'd15);
    add_op(OP_POP_TAIL, '0, 4'd0);
    add_op(OP_WR_BYTE, '1, 4'd0);
    add_capacity(13'd0);
    add_op(OP_RESET_POS, '0, 4'd0);
    add_op(OP_WR_BITS, '1, 4'd1);
    add_op(OP_RD_W64, '0, 4'd0);

    // fill the whole store past its end with capacity saturated to the depth
    add_capacity(13'd8191);
    add_op(OP_RESET_POS, '0, 4'd0);
    repeat (700) add_random(1'b1);

    add_capacity(13'd9);
    repeat (195) add_random(1'b0);
    add_capacity(CapReset);
    repeat (195) add_random(1'b0);
    add_capacity(13'd1);
    repeat (195) add_random(1'b0);
    add_capacity(13'($urandom_range(16, 600)));
    repeat (195) add_random(1'b0);
    add_capacity(13'd2);
    repeat (195) add_random(1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (!(stim_done && ops_sent == reports_seen));
    repeat (30) @(posedge clk_i);

    $display("%0d transactions checked under %0d capacity writes", reports_seen, cap_writes);
    $display("status mix: %0d ok, %0d bad length, %0d past capacity",
             status_hits[ST_OK], status_hits[ST_LEN], status_hits[ST_CAP]);
    if (fail_n == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout: %0d of %0d results seen", reports_seen, ops_sent);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== lsb_first_bit_buffer.f =====
rtl/lbb_pkg.sv
rtl/lbb_store.sv
rtl/lsb_first_bit_buffer.sv
test/lsb_first_bit_buffer_test.sv
